FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, masked while rst_ni is low.
`define LPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: when ante holds, cons holds in the same cycle.
`define LPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication form: when ante holds, cons holds in the next cycle.
`define LPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lpr_pkg.sv
// Types and constants of the LRU page frame replacer.
package lpr_pkg;

  localparam int unsigned LPR_IDX_W = 6;   // frame index / rank, up to 64 frames
  localparam int unsigned LPR_CNT_W = 7;   // counts 0..64
  localparam int unsigned LPR_CFG_W = 5;
  localparam logic [LPR_CFG_W-1:0] LPR_CFG_RESET = 5'd16;
  localparam logic [31:0] LPR_TOTAL_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] page_number;
  } lpr_in_t;

  typedef struct packed {
    logic        was_hit;
    logic [3:0]  frame_index;
    logic [31:0] hit_total;
    logic [31:0] fault_total;
  } lpr_out_t;

  typedef struct packed {
    logic [LPR_CFG_W-1:0] frames_in_use;
  } lpr_cfg_t;

  // Search token walking along the cell row.
  typedef struct packed {
    logic                 active;
    logic                 hit;
    logic [LPR_IDX_W-1:0] hit_idx;
    logic [LPR_IDX_W-1:0] hit_rank;
    logic                 empty_found;
    logic [LPR_IDX_W-1:0] empty_idx;
    logic                 lru_set;
    logic [LPR_IDX_W-1:0] lru_idx;
    logic [LPR_IDX_W-1:0] lru_rank;
  } lpr_tok_t;

  // Update broadcast to all cells once a decision is made.
  typedef struct packed {
    logic                 en;
    logic                 page_wr;
    logic [LPR_IDX_W-1:0] frame;
    logic                 tgt_valid;   // target frame already held a page
    logic [LPR_IDX_W-1:0] old_rank;
    logic [LPR_CNT_W-1:0] vcnt;        // valid frames before this update
  } lpr_upd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } lpr_state_e;

endpackage

FILE: rtl/core/lpr_stream_if.sv
// Valid/ready channel interface with a typed payload.
interface lpr_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/lpr_cell.sv
// One frame cell: page, valid bit and recency rank, plus one search-token stage.
module lpr_cell import lpr_pkg::*; #(
  parameter int unsigned PAGE_BITS = 16,
  parameter int unsigned RANK_W    = 4,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [LPR_CNT_W-1:0] n_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  lpr_tok_t             tok_i,
  output lpr_tok_t             tok_o,
  input  lpr_upd_t             upd_i
);

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid_q;
  logic [RANK_W-1:0]    rank_q, rank_d;
  logic                 valid_d;
  lpr_tok_t             tok_q, tok_d;
  logic                 in_rng;
  logic                 sel;

  assign in_rng = LPR_CNT_W'(IDX) < n_i;
  assign sel    = upd_i.frame == LPR_IDX_W'(IDX);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.active && in_rng) begin
      if (!tok_i.hit && valid_q && (page_q == page_i)) begin
        tok_d.hit      = 1'b1;
        tok_d.hit_idx  = LPR_IDX_W'(IDX);
        tok_d.hit_rank = LPR_IDX_W'(rank_q);
      end
      if (!tok_i.empty_found && !valid_q) begin
        tok_d.empty_found = 1'b1;
        tok_d.empty_idx   = LPR_IDX_W'(IDX);
      end
      if (!tok_i.lru_set || (rank_q < tok_i.lru_rank[RANK_W-1:0])) begin
        tok_d.lru_set  = 1'b1;
        tok_d.lru_idx  = LPR_IDX_W'(IDX);
        tok_d.lru_rank = LPR_IDX_W'(rank_q);
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (upd_i.en) begin
      if (sel) begin
        valid_d = 1'b1;
        rank_d  = upd_i.tgt_valid ? RANK_W'(upd_i.vcnt - LPR_CNT_W'(1))
                                  : RANK_W'(upd_i.vcnt);
      end else if (upd_i.tgt_valid && valid_q &&
                   (LPR_IDX_W'(rank_q) > upd_i.old_rank)) begin
        rank_d = rank_q - RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      tok_q   <= tok_d;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (upd_i.en && sel && upd_i.page_wr) begin
      page_q <= page_i;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: rtl/core/lru_page_frame_replacer.sv
// Top level of the LRU page frame replacer: control, totals and the cell row.
//
// Fully associative LRU page frame replacer. Each page reference on req_i
// produces one result on rsp_o: hit or fault, the frame that held or now
// holds the page, and saturating 32-bit hit and fault totals. The frames
// form a row of FRAMES cells; a search token enters cell 0 in the cycle after
// the reference is taken and moves one cell per cycle, collecting the first
// matching frame, the first empty frame and the least recent frame of the
// active range. When it leaves the row it is captured, and once the output
// register is empty or being read, the decision is broadcast back to all
// cells (recency ranks shift, the target frame is written) and the result
// is registered. Only one reference is in progress at a time: the input is
// ready again only in idle. A new reference is taken once the previous
// decision has been applied; a result waiting in the output register does
// not block the next transfer, only the decision of that next reference.
// frames_in_use (cfg_i) selects how
// many frames take part: 0 acts as 1, values above FRAMES act as FRAMES.
// Frames outside the active range keep their contents and their place in
// the recency order. Page numbers are masked to PAGE_BITS bits. No clearing
// pass is needed after reset.
module lru_page_frame_replacer import lpr_pkg::*; #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lpr_stream_if.sink   cfg_i,
  lpr_stream_if.sink   req_i,
  lpr_stream_if.source rsp_o
);

`include "assert_macros.svh"

  localparam int unsigned RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  lpr_state_e state_q, state_d;

  logic [LPR_CFG_W-1:0] frames_q;          // frames_in_use register
  logic [LPR_CNT_W-1:0] n_q, n_d;          // active frame count, latched per item
  logic [PAGE_BITS-1:0] pg_q;
  logic [31:0]          pg_ext;
  logic                 inj_q;             // token injection into cell 0
  logic [LPR_CNT_W-1:0] vcnt_q;            // number of valid frames
  logic [31:0]          hit_q, fault_q;
  lpr_tok_t             fin_q;             // token captured at the row end
  lpr_out_t             out_q, out_d;
  logic                 out_vld_q;

  lpr_tok_t             tok[FRAMES+1];
  logic [FRAMES-1:0]    tok_act;
  lpr_upd_t             upd;

  logic                 req_xfer;
  logic                 cap;               // capture token leaving the row
  logic                 commit;            // apply decision, load result
  logic [LPR_IDX_W-1:0] frame;

  assign req_xfer    = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // Page mask: zero-extend, then keep PAGE_BITS bits.
  assign pg_ext = 32'(req_i.data.page_number);

  // Clamp frames_in_use into 1..FRAMES.
  always_comb begin
    if (frames_q == '0) begin
      n_d = LPR_CNT_W'(1);
    end else if (LPR_CNT_W'(frames_q) > LPR_CNT_W'(FRAMES)) begin
      n_d = LPR_CNT_W'(FRAMES);
    end else begin
      n_d = LPR_CNT_W'(frames_q);
    end
  end

  // Token entering cell 0
  always_comb begin
    tok[0]        = '0;
    tok[0].active = inj_q;
  end

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lpr_cell #(
      .PAGE_BITS(PAGE_BITS),
      .RANK_W   (RANK_W),
      .IDX      (g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .n_i   (n_q),
      .page_i(pg_q),
      .tok_i (tok[g]),
      .tok_o (tok[g+1]),
      .upd_i (upd)
    );
    assign tok_act[g] = tok[g+1].active;
  end

  // Decision from the captured token: hit frame, else first empty, else LRU.
  always_comb begin
    if (fin_q.hit) begin
      frame = fin_q.hit_idx;
    end else if (fin_q.empty_found) begin
      frame = fin_q.empty_idx;
    end else begin
      frame = fin_q.lru_idx;
    end
  end

  // FSM next state and strobes
  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    cap         = 1'b0;
    commit      = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok[FRAMES].active) begin
          cap     = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || rsp_o.ready) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    upd.en        = commit;
    upd.page_wr   = !fin_q.hit;
    upd.frame     = frame;
    upd.tgt_valid = fin_q.hit || !fin_q.empty_found;
    upd.old_rank  = fin_q.hit ? fin_q.hit_rank : fin_q.lru_rank;
    upd.vcnt      = vcnt_q;
  end

  always_comb begin
    out_d.was_hit     = fin_q.hit;
    out_d.frame_index = frame[3:0];
    out_d.hit_total   = hit_q;
    out_d.fault_total = fault_q;
    if (fin_q.hit) begin
      if (hit_q != LPR_TOTAL_MAX) out_d.hit_total = hit_q + 32'd1;
    end else begin
      if (fault_q != LPR_TOTAL_MAX) out_d.fault_total = fault_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      frames_q  <= LPR_CFG_RESET;
      inj_q     <= 1'b0;
      vcnt_q    <= '0;
      hit_q     <= '0;
      fault_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      inj_q   <= req_xfer;
      if (cfg_i.valid) begin
        frames_q <= cfg_i.data.frames_in_use;
      end
      if (commit) begin
        hit_q   <= out_d.hit_total;
        fault_q <= out_d.fault_total;
        if (!upd.tgt_valid) begin
          vcnt_q <= vcnt_q + LPR_CNT_W'(1);
        end
      end
      if (commit) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      pg_q <= pg_ext[PAGE_BITS-1:0];
      n_q  <= n_d;
    end
    if (cap) begin
      fin_q <= tok[FRAMES];
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.data  = out_q;

  // Only one reference may be in the row at a time.
  `LPR_ASSERT(a_one_token, $countones({inj_q, tok_act}) <= 1, "more than one token in flight")
  // Valid count never exceeds the frame count.
  `LPR_ASSERT(a_vcnt_max, vcnt_q <= LPR_CNT_W'(FRAMES), "valid frame count overflow")
  // Filling an empty frame requires a free frame to exist.
  `LPR_ASSERT_IMP(a_fill_room, commit && !upd.tgt_valid, vcnt_q < LPR_CNT_W'(FRAMES),
                  "empty frame chosen with all frames valid")
  // Exactly one total moves on each commit unless either total is saturated.
  `LPR_ASSERT_NXT(a_totals, commit && (hit_q != LPR_TOTAL_MAX) && (fault_q != LPR_TOTAL_MAX),
                  (hit_q + fault_q) == ($past(hit_q) + $past(fault_q) + 32'd1),
                  "totals did not advance by one")

endmodule
